// ----- hw/rtl/length_prefixed_varint_codec_assert.svh -----
// Assertion macros for the varint codec checkers.
`ifndef LENGTH_PREFIXED_VARINT_CODEC_ASSERT_SVH
`define LENGTH_PREFIXED_VARINT_CODEC_ASSERT_SVH

// Clocked assertion, held off while reset is asserted.
`define LPVC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication form: when the antecedent holds, the consequent holds in the next cycle.
`define LPVC_ASSERT_NEXT(label, ante, cons, msg) \
	`LPVC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/lpvc_pkg.sv -----
`timescale 1ns / 1ps
package lpvc_pkg;

	localparam int PADDR_W = 3;

	localparam logic FMT_ONE_BIT = 1'b0;
	localparam logic FMT_TWO_BIT = 1'b1;

	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	localparam logic REG_FORMAT = 1'b0;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_WIDE  = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	typedef struct packed {
		logic        too_wide;
		logic [31:0] word;
		logic [2:0]  len;
	} enc_res_t;

	typedef struct packed {
		logic        emit;
		logic        done;
		logic [29:0] value;
		logic [2:0]  len;
		logic [1:0]  status;
	} dec_res_t;

endpackage

// ----- hw/rtl/lpvc_enc.sv -----
`timescale 1ns / 1ps
module lpvc_enc import lpvc_pkg::*; (
	input  logic        fmt,
	input  logic [31:0] value,
	output enc_res_t    res
);

	logic [31:0] w2;

	assign w2 = {value[29:0], 2'b00};

	always_comb begin
		res = '0;
		if (fmt == FMT_ONE_BIT) begin
			res.too_wide = (value[31:15] != '0);
			res.word = {value[30:0], 1'b0};
			if (value[14:7] != '0) begin
				res.word[0] = 1'b1;
				res.len = 3'd2;
			end else begin
				res.len = 3'd1;
			end
		end else begin
			res.too_wide = (value[31:30] != '0);
			res.word = w2;
			// length from the highest nonzero byte of the shifted word
			priority if (w2[31:24] != '0) res.len = 3'd4;
			else if (w2[23:16] != '0)     res.len = 3'd3;
			else if (w2[15:8] != '0)      res.len = 3'd2;
			else                          res.len = 3'd1;
			res.word[1:0] = res.len[1:0] - 2'd1;
		end
	end

endmodule

// ----- hw/rtl/lpvc_dec.sv -----
`timescale 1ns / 1ps
module lpvc_dec import lpvc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fmt,
	input  logic       clear,
	input  logic       step,
	input  logic [7:0] byte_in,
	input  logic       buffer_end,
	output dec_res_t   res
);

	logic [2:0]  collected_q;
	logic [2:0]  expected_q;
	logic [23:0] partial_q;

	logic [2:0]  exp_len;
	logic [2:0]  cnt;
	logic [31:0] word;
	logic        complete;

	always_comb begin
		if (collected_q != '0) begin
			exp_len = expected_q;
		end else if (fmt == FMT_ONE_BIT) begin
			exp_len = byte_in[0] ? 3'd2 : 3'd1;
		end else begin
			exp_len = {1'b0, byte_in[1:0]} + 3'd1;
		end
		word = {8'd0, partial_q} | ({24'd0, byte_in} << {collected_q[1:0], 3'b000});
		cnt = collected_q + 3'd1;
		complete = (cnt >= exp_len);

		res = '0;
		if (complete) begin
			res.emit = 1'b1;
			res.done = 1'b1;
			res.len = exp_len;
			res.status = ST_OK;
			res.value = (fmt == FMT_ONE_BIT) ? {15'd0, word[15:1]} : word[31:2];
		end else if (buffer_end) begin
			res.emit = 1'b1;
			res.status = ST_TRUNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collected_q <= '0;
			expected_q <= '0;
			partial_q <= '0;
		end else if (clear || (step && (complete || buffer_end))) begin
			collected_q <= '0;
			expected_q <= '0;
			partial_q <= '0;
		end else if (step) begin
			collected_q <= cnt;
			expected_q <= exp_len;
			partial_q <= word[23:0];
		end
	end

endmodule

// ----- hw/rtl/length_prefixed_varint_codec.sv -----
`timescale 1ns / 1ps
// Channel   | Dir | Handshake                 | Content
// s_*       | in  | s_tvalid / s_tready       | request word: value, byte, kind, buffer end
// m_*       | out | m_tvalid / m_tready       | result word: byte, value, length, flags
// APB       | in  | psel, penable, pready = 1 | format_select at address 0
//
// A word is held in the input register and is then emitted into the
// one-word output register. Decode words yield at most one result; encode
// words yield one per code byte (1 to 4), bounded by the single output register.
// An error result is a single word; a decode byte with no result retires at once.
// Reset (arst_n low) empties both registers, clears decode state, sets format 1.
// A stalled m_tready holds the output word and backs up into s_tready.
module length_prefixed_varint_codec import lpvc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// slave stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [39:0]        s_tdata,  // [31:0] value_in, [39:32] byte_in
	input  logic               s_tuser,  // [0] req_type
	input  logic               s_tlast,  // buffer_end
	// master stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,  // [7:0] byte_out, [37:8] value_out,
	                                     // [40:38] code_length, [47:41] zero
	output logic [3:0]         m_tuser,  // [0] byte_valid, [1] value_valid, [3:2] status
	output logic               m_tlast,  // last
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// configuration register
	logic fmt_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FORMAT);
	assign prdata = (paddr[2] == REG_FORMAT) ? {31'd0, fmt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_TWO_BIT;
		end else if (cfg_wr) begin
			fmt_q <= pwdata[0];
		end
	end

	// input register
	logic        valid_s1;
	logic        req_s1;
	logic [31:0] value_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	logic [1:0]  idx_q;
	logic        out_free;
	logic        produce;
	logic        consume;
	logic        is_enc;
	logic        enc_last;
	logic [7:0]  enc_byte;
	enc_res_t    enc_res;
	dec_res_t    dec_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= s_tuser;
			value_s1 <= s_tdata[31:0];
			byte_s1 <= s_tdata[39:32];
			end_s1 <= s_tlast;
		end
	end

	lpvc_enc u_enc (
		.fmt   (fmt_q),
		.value (value_s1),
		.res   (enc_res)
	);

	lpvc_dec u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.fmt        (fmt_q),
		.clear      (cfg_wr),
		.step       (valid_s1 && (req_s1 == REQ_DECODE) && consume),
		.byte_in    (byte_s1),
		.buffer_end (end_s1),
		.res        (dec_res)
	);

	// pick the code byte for the current position
	always_comb begin
		unique case (idx_q)
			2'd0: enc_byte = enc_res.word[7:0];
			2'd1: enc_byte = enc_res.word[15:8];
			2'd2: enc_byte = enc_res.word[23:16];
			2'd3: enc_byte = enc_res.word[31:24];
			default: enc_byte = enc_res.word[7:0];
		endcase
	end

	assign is_enc = (req_s1 == REQ_ENCODE);
	assign enc_last = enc_res.too_wide || (({1'b0, idx_q} + 3'd1) == enc_res.len);
	assign out_free = !m_tvalid || m_tready;
	assign produce = valid_s1 && out_free && (is_enc || dec_res.emit);
	// a decode byte without a result retires even while the output is full
	assign consume = valid_s1 && (is_enc ? (out_free && enc_last)
	                                     : (!dec_res.emit || out_free));
	assign s_tready = !valid_s1 || consume;

	// advance through the code bytes, reset on retire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (consume) begin
			idx_q <= '0;
		end else if (produce && is_enc) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// output register
	logic        m_valid_q;
	logic [7:0]  byte_q;
	logic        bvalid_q;
	logic [29:0] value_q;
	logic        vvalid_q;
	logic [2:0]  len_q;
	logic [1:0]  status_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			if (is_enc && enc_res.too_wide) begin
				byte_q <= '0;
				bvalid_q <= 1'b0;
				value_q <= '0;
				vvalid_q <= 1'b0;
				len_q <= '0;
				status_q <= ST_WIDE;
				last_q <= 1'b1;
			end else if (is_enc) begin
				byte_q <= enc_byte;
				bvalid_q <= 1'b1;
				value_q <= '0;
				vvalid_q <= 1'b0;
				len_q <= enc_res.len;
				status_q <= ST_OK;
				last_q <= enc_last;
			end else begin
				byte_q <= '0;
				bvalid_q <= 1'b0;
				value_q <= dec_res.value;
				vvalid_q <= dec_res.done;
				len_q <= dec_res.len;
				status_q <= dec_res.status;
				last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {7'd0, len_q, value_q, byte_q};
	assign m_tuser = {status_q, vvalid_q, bvalid_q};
	assign m_tlast = last_q;

endmodule

// ----- hw/rtl/lpvc_checker.sv -----
`timescale 1ns / 1ps
`include "length_prefixed_varint_codec_assert.svh"
module lpvc_checker import lpvc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [47:0]        m_tdata,
	input logic [3:0]         m_tuser,
	input logic               m_tlast,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready
);

	logic [2:0] m_len;
	logic [1:0] m_status;
	logic       m_bvalid;
	logic       m_vvalid;
	logic       byte_ok;
	logic       err_ok;
	logic       fmt_addr;
	logic       fmt_wr;

	assign m_len    = m_tdata[40:38];
	assign m_status = m_tuser[3:2];
	assign m_bvalid = m_tuser[0];
	assign m_vvalid = m_tuser[1];
	assign byte_ok  = (m_len != 3'd0) && !m_vvalid && (m_status == ST_OK);
	assign err_ok   = m_tlast && (m_len == 3'd0) && !m_bvalid && !m_vvalid;
	assign fmt_addr = (paddr[2] == REG_FORMAT);
	assign fmt_wr   = psel && penable && pwrite && pready && fmt_addr;

	// hold a stalled result
	`LPVC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	// code bytes carry a length and never a value
	`LPVC_ASSERT(a_byte_len, !(m_tvalid && m_bvalid) || byte_ok, "bad code byte result")

	// error results stand alone with length zero
	`LPVC_ASSERT(a_err_alone, !(m_tvalid && m_status != ST_OK) || err_ok, "bad error result")

	// format register reads back what was written
	`LPVC_ASSERT_NEXT(a_fmt_rb, fmt_wr, !fmt_addr || prdata[0] == $past(pwdata[0]), "bad readback")

endmodule

bind length_prefixed_varint_codec lpvc_checker u_lpvc_checker (.*);
